FILE: design/bounded_set_table_core_defines.svh
// Assertion macros shared by the bounded set table design.
// Both macros sample on the rising edge of clk and are disabled during reset.
`ifndef BOUNDED_SET_TABLE_CORE_DEFINES_SVH
`define BOUNDED_SET_TABLE_CORE_DEFINES_SVH

// The expression must hold at every clock edge.
`define BST_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define BST_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: design/bst_pkg.sv
package bst_pkg;

    // Command codes carried by an input beat.
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_REMOVE   = 2'd1,
        CMD_CONTAINS = 2'd2,
        CMD_CLEAR    = 2'd3
    } bst_cmd_t;

    // Token that walks the row of cells, one cell per cycle.
    typedef struct packed {
        logic     active;
        bst_cmd_t cmd;
        logic     hit;
    } bst_token_t;

    // Width of the count field of a result beat.
    localparam int unsigned CountFieldWidth = 5;

endpackage

FILE: design/bst_cell.sv
module bst_cell
    import bst_pkg::*;
#(
    parameter int ITEM_WIDTH = 32,
    parameter int CNT_W      = 5,
    parameter int IDX        = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  bst_token_t            tok_in,
    input  logic [ITEM_WIDTH-1:0] val_in,
    input  logic [CNT_W-1:0]      held_count,
    input  logic                  wr_en,
    input  logic [ITEM_WIDTH-1:0] wr_data,
    input  logic                  pull,
    input  logic [ITEM_WIDTH-1:0] above_entry,
    output bst_token_t            tok_out,
    output logic [ITEM_WIDTH-1:0] val_out,
    output logic                  shift_req,
    output logic [ITEM_WIDTH-1:0] entry
);

    bst_token_t            tok_reg;
    bst_token_t            tok_next;
    logic [ITEM_WIDTH-1:0] val_reg;
    logic [ITEM_WIDTH-1:0] entry_reg;
    logic [ITEM_WIDTH-1:0] entry_next;
    logic                  match;

    // This slot matches when it is in use and holds the looked-up value.
    assign match = tok_in.active && (CNT_W'(IDX) < held_count) && (entry_reg == val_in);

    // Fold the local compare into the token's hit flag.
    always_comb
    begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | match;
    end

    // Once a remove has found its value below this slot, the lower neighbor
    // takes this slot's entry, closing the gap one slot per cycle.
    assign shift_req = tok_in.active && (tok_in.cmd == CMD_REMOVE) && tok_in.hit;

    // An add writes the slot directly; a remove pulls from the slot above.
    always_comb
    begin
        if (wr_en)
        begin
            entry_next = wr_data;
        end
        else if (pull)
        begin
            entry_next = above_entry;
        end
        else
        begin
            entry_next = entry_reg;
        end
    end

    // Token state is control and is reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // Value and entry are payload only.
    always_ff @(posedge clk)
    begin
        val_reg   <= val_in;
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;
    assign val_out = val_reg;
    assign entry   = entry_reg;

endmodule

FILE: design/bounded_set_table_core.sv
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_stall    command, value
// out      output     out_valid / out_stall  success, count, empty_res
//
// Each command's token walks the row of CAPACITY cells, one cell per cycle,
// comparing and compacting entries as it passes; its result then goes to
// the output register. No new beat is taken until the sequencer is back in
// idle, so only one command is in the row at a time.
// Reset clears the entry count, the cell tokens and the output valid flag.
// A stalled result is held; a finished command waits in a result register
// until the output register is free, and no new beat is taken meanwhile.
`include "bounded_set_table_core_defines.svh"

module bounded_set_table_core
    import bst_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int ITEM_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        success,
    output logic [CountFieldWidth-1:0] count,
    output logic        empty_res
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_HOLD = 3'b100
    } bst_state_t;

    bst_state_t state_reg;
    bst_state_t state_next;

    logic [CNT_W-1:0] held_count_reg;
    logic [CNT_W-1:0] held_count_next;
    logic [CNT_W-1:0] fin_count;

    logic                       res_success_reg;
    logic                       res_success_next;
    logic [CountFieldWidth-1:0] res_count_reg;
    logic [CountFieldWidth-1:0] res_count_next;
    logic                       res_empty_reg;
    logic                       res_empty_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_success_reg;
    logic                       out_success_next;
    logic [CountFieldWidth-1:0] out_count_reg;
    logic [CountFieldWidth-1:0] out_count_next;
    logic                       out_empty_reg;
    logic                       out_empty_next;

    logic in_accept;
    logic out_free;
    logic fin;
    logic fin_ok;
    logic add_wr;

    bst_token_t            tok_link [0:CAPACITY];
    logic [ITEM_WIDTH-1:0] val_link [0:CAPACITY];
    logic [ITEM_WIDTH-1:0] entry_w  [0:CAPACITY];
    logic                  shift_w  [0:CAPACITY];
    logic [CAPACITY-1:0]   tok_active;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Inject the token into the first cell on an accepted beat.
    always_comb
    begin
        tok_link[0]        = '0;
        tok_link[0].active = in_accept;
        tok_link[0].cmd    = bst_cmd_t'(command);
        tok_link[0].hit    = 1'b0;
    end
    assign val_link[0] = ITEM_WIDTH'(value);

    // Nothing sits above the last cell.
    assign entry_w[CAPACITY] = '0;
    assign shift_w[CAPACITY] = 1'b0;

    // The row of cells.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic cell_wr;

            assign cell_wr = add_wr && (held_count_reg == CNT_W'(gi));

            bst_cell #(
                .ITEM_WIDTH (ITEM_WIDTH),
                .CNT_W      (CNT_W),
                .IDX        (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .tok_in      (tok_link[gi]),
                .val_in      (val_link[gi]),
                .held_count  (held_count_reg),
                .wr_en       (cell_wr),
                .wr_data     (val_link[CAPACITY]),
                .pull        (shift_w[gi+1]),
                .above_entry (entry_w[gi+1]),
                .tok_out     (tok_link[gi+1]),
                .val_out     (val_link[gi+1]),
                .shift_req   (shift_w[gi]),
                .entry       (entry_w[gi])
            );

            assign tok_active[gi] = tok_link[gi+1].active;
        end
    endgenerate

    // Settle the command once its token leaves the last cell.
    assign fin = tok_link[CAPACITY].active;

    always_comb
    begin
        fin_ok    = 1'b0;
        fin_count = held_count_reg;
        case (tok_link[CAPACITY].cmd)
            CMD_ADD:
            begin
                fin_ok = !tok_link[CAPACITY].hit && (held_count_reg < CNT_W'(CAPACITY));
                if (fin_ok)
                begin
                    fin_count = held_count_reg + CNT_W'(1);
                end
            end
            CMD_REMOVE:
            begin
                fin_ok = tok_link[CAPACITY].hit;
                if (fin_ok)
                begin
                    fin_count = held_count_reg - CNT_W'(1);
                end
            end
            CMD_CONTAINS:
            begin
                fin_ok = tok_link[CAPACITY].hit;
            end
            default:
            begin
                fin_ok    = 1'b1;
                fin_count = '0;
            end
        endcase
    end

    assign add_wr = fin && (tok_link[CAPACITY].cmd == CMD_ADD) && fin_ok;

    // Sequencer, count update and result staging.
    always_comb
    begin
        state_next       = state_reg;
        held_count_next  = held_count_reg;
        res_success_next = res_success_reg;
        res_count_next   = res_count_reg;
        res_empty_next   = res_empty_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_success_next = out_success_reg;
        out_count_next   = out_count_reg;
        out_empty_next   = out_empty_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (fin)
                begin
                    held_count_next  = fin_count;
                    res_success_next = fin_ok;
                    res_count_next   = CountFieldWidth'(fin_count);
                    res_empty_next   = (fin_count == '0);
                    if (out_free)
                    begin
                        out_valid_next   = 1'b1;
                        out_success_next = fin_ok;
                        out_count_next   = CountFieldWidth'(fin_count);
                        out_empty_next   = (fin_count == '0);
                        state_next       = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_success_next = res_success_reg;
                    out_count_next   = res_count_reg;
                    out_empty_next   = res_empty_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_count_reg <= held_count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        res_success_reg <= res_success_next;
        res_count_reg   <= res_count_next;
        res_empty_reg   <= res_empty_next;
        out_success_reg <= out_success_next;
        out_count_reg   <= out_count_next;
        out_empty_reg   <= out_empty_next;
    end

    assign out_valid = out_valid_reg;
    assign success   = out_success_reg;
    assign count     = out_count_reg;
    assign empty_res = out_empty_reg;

    // The table never holds more entries than it has slots.
    `BST_ASSERT_ALWAYS(a_count_bound, held_count_reg <= CNT_W'(CAPACITY), "count exceeds capacity")
    // Only one command walks the row at a time.
    `BST_ASSERT_ALWAYS(a_one_token, $onehot0(tok_active), "more than one token in the row")
    // An idle sequencer has no token left in the row.
    `BST_ASSERT_IMPL(a_idle_empty_row, state_reg == ST_IDLE, tok_active == '0, "token in row while idle")
    // A result is only parked while the output register is occupied.
    `BST_ASSERT_IMPL(a_hold_needs_out, state_reg == ST_HOLD, out_valid_reg, "hold with free output")

endmodule

FILE: verif/testbench.sv
module testbench
    import bst_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int VALUE_BITS  = 32;
    localparam int RANDOM_BEATS = 558;
    localparam int POOL_SIZE   = 24;
    localparam realtime TIMEOUT_NS = 2_000_000.0;

    // Predicts each reply of the table and checks it against the result beats.
    class set_table_tracker;
        typedef struct packed {
            logic                       hit;
            logic [CountFieldWidth-1:0] held;
            logic                       none_held;
        } table_reply_t;

        logic [VALUE_BITS-1:0] slots [SLOTS];
        int unsigned           held;
        table_reply_t          pending_replies [$];
        int                    mismatches;
        int                    replies_checked;
        int                    per_command [4];
        int                    full_refusals;

        function new();
            held            = 0;
            mismatches      = 0;
            replies_checked = 0;
            full_refusals   = 0;
            foreach (per_command[i]) per_command[i] = 0;
        endfunction

        // Position of a value among the held entries, or -1 when absent.
        function int locate(logic [VALUE_BITS-1:0] val);
            for (int i = 0; i < held; i++)
            begin
                if (slots[i] == val)
                    return i;
            end
            return -1;
        endfunction

        function logic [VALUE_BITS-1:0] pick_held();
            return slots[$urandom_range(0, held - 1)];
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, what);
        endfunction

        // Applies an accepted command beat to the table and queues its reply.
        function void note_command(bst_cmd_t cmd, logic [VALUE_BITS-1:0] val);
            int           pos;
            logic         ok;
            table_reply_t reply;
            pos = locate(val);
            ok  = 1'b0;
            per_command[cmd]++;
            case (cmd)
                CMD_ADD:
                begin
                    if (pos < 0 && held < SLOTS)
                    begin
                        slots[held] = val;
                        held++;
                        ok = 1'b1;
                    end
                    else if (pos < 0)
                    begin
                        full_refusals++;
                    end
                end
                CMD_REMOVE:
                begin
                    // The last entry fills the freed slot.
                    if (pos >= 0)
                    begin
                        held--;
                        slots[pos] = slots[held];
                        ok = 1'b1;
                    end
                end
                CMD_CONTAINS:
                begin
                    ok = (pos >= 0);
                end
                default:
                begin
                    held = 0;
                    ok   = 1'b1;
                end
            endcase
            reply.hit       = ok;
            reply.held      = held[CountFieldWidth-1:0];
            reply.none_held = (held == 0);
            pending_replies = {pending_replies, reply};
        endfunction

        // Compares one result beat with the oldest queued reply.
        function void check_result(logic hit, logic [CountFieldWidth-1:0] cnt, logic none);
            table_reply_t want;
            if (pending_replies.size() == 0)
            begin
                flag($sformatf("result beat with no reply expected (%0b %0d %0b)",
                               hit, cnt, none));
                return;
            end
            want = pending_replies.pop_front();
            replies_checked++;
            if (hit !== want.hit || cnt !== want.held || none !== want.none_held)
                flag($sformatf("expected success %0b count %0d empty %0b, got %0b %0d %0b",
                               want.hit, want.held, want.none_held, hit, cnt, none));
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [1:0]                 command = CMD_CLEAR;
    logic [31:0]                value = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       success;
    logic [CountFieldWidth-1:0] count;
    logic                       empty_res;

    int                    send_gap_pct = 25;
    int                    stall_pct    = 45;
    logic [VALUE_BITS-1:0] value_pool [POOL_SIZE];
    set_table_tracker      tracker = new();

    bounded_set_table_core #(
        .CAPACITY   (SLOTS),
        .ITEM_WIDTH (VALUE_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .success   (success),
        .count     (count),
        .empty_res (empty_res)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Random backpressure on the result channel.
    always @(negedge clk)
    begin
        out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
    end

    // Both channels are sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            tracker.note_command(bst_cmd_t'(command), value);
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(success, count, empty_res);
    end

    // Sends one command beat; called at a falling edge, returns at one.
    task automatic send_command(input bst_cmd_t cmd, input logic [31:0] val);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        value    <= val;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Mostly well-formed traffic: adds from a small pool so the table fills,
    // removes and lookups aimed at held values, and an occasional clear.
    task automatic send_random(input int beats);
        int                    pick;
        bst_cmd_t              cmd;
        logic [VALUE_BITS-1:0] val;
        for (int n = 0; n < beats; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                cmd = CMD_ADD;
            else if (pick < 70)
                cmd = CMD_REMOVE;
            else if (pick < 97)
                cmd = CMD_CONTAINS;
            else
                cmd = CMD_CLEAR;
            if (cmd != CMD_ADD && tracker.held > 0 && $urandom_range(0, 99) < 55)
                val = tracker.pick_held();
            else if ($urandom_range(0, 99) < 70)
                val = value_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                val = $urandom();
            send_command(cmd, val);
        end
    endtask

    initial
    begin
        #TIMEOUT_NS;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        value_pool[0] = '0;
        value_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            value_pool[i] = $urandom();

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty-table corner cases.
        send_command(CMD_CLEAR, 32'hFFFF_FFFF);
        send_command(CMD_REMOVE, 32'h0000_0000);
        send_command(CMD_CONTAINS, 32'h0000_0000);

        // Extreme values, a duplicate add, then fill to capacity.
        send_command(CMD_ADD, 32'h0000_0000);
        send_command(CMD_ADD, 32'hFFFF_FFFF);
        send_command(CMD_ADD, 32'h0000_0000);
        for (int i = 0; i < SLOTS - 2; i++)
            send_command(CMD_ADD, 32'h8000_0000 >> i);
        send_command(CMD_ADD, 32'h1234_5678);

        // Lookups and removals on a full table, then clear it.
        send_command(CMD_CONTAINS, 32'hFFFF_FFFF);
        send_command(CMD_REMOVE, 32'h0000_0000);
        send_command(CMD_REMOVE, 32'h1234_5678);
        send_command(CMD_CONTAINS, 32'h0000_0000);
        send_command(CMD_REMOVE, 32'h8000_0000 >> (SLOTS - 3));
        send_command(CMD_CLEAR, 32'h5A5A_A5A5);

        // Random part in three pacing phases.
        send_random(RANDOM_BEATS);
        send_gap_pct = 45;
        stall_pct    = 25;
        send_random(RANDOM_BEATS);
        send_gap_pct = 0;
        stall_pct    = 0;
        send_random(RANDOM_BEATS);
        in_valid <= 1'b0;

        // Drain, then watch for stray result beats.
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 4) @(posedge clk);

        $display("Sent %0d adds, %0d removes, %0d lookups and %0d clears; %0d results checked.",
                 tracker.per_command[CMD_ADD], tracker.per_command[CMD_REMOVE],
                 tracker.per_command[CMD_CONTAINS], tracker.per_command[CMD_CLEAR],
                 tracker.replies_checked);
        $display("Adds refused on a full table: %0d; mismatches: %0d.",
                 tracker.full_refusals, tracker.mismatches);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
